### rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BBM_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bbm assertion failed");

// The condition must hold in the cycle after the trigger.
`define BBM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bbm assertion failed");

`endif

### rtl/bbm_pkg.sv
package bbm_pkg;

   // Fixed field widths of the request and response items.
   localparam int BLOCK_BITS = 48;
   localparam int OP_W       = 2;
   localparam int RUN_W      = 6;
   localparam int CHUNK_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int HIT_W      = 6;
   localparam int FREED_W    = 5;
   localparam int ITEMS_W    = 11;
   localparam int BUCKETS_W  = 5;

   // Longest run that one request may cover.
   localparam int MAX_RUN = 32;

   // Entries per bucket; a power of two, so key and slot are plain bit fields.
   localparam int ENTRIES_PER_BUCKET = 64;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CLEAR,
      S_READ,
      S_RDATA,
      S_FLUSH,
      S_RESP
   } state_type;

endpackage

### rtl/bbm_if.sv
// Request channel: one item per map operation.
interface bbm_req_if import bbm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [BLOCK_BITS-1:0] start_block;
   logic [RUN_W-1:0]      run_length;
   logic [CHUNK_W-1:0]    new_chunk;

   modport source (output valid, operation, start_block, run_length, new_chunk,
                   input ready);
   modport sink (input valid, operation, start_block, run_length, new_chunk,
                 output ready);
endinterface

// Response channel: one item per operation, or one per block for find.
interface bbm_rsp_if import bbm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [CHUNK_W-1:0]   chunk_id;
   logic                 present;
   logic [HIT_W-1:0]     hit_count;
   logic [FREED_W-1:0]   freed_count;
   logic [ITEMS_W-1:0]   items_held;
   logic [BUCKETS_W-1:0] buckets_held;
   logic                 last;

   modport source (output valid, status, chunk_id, present, hit_count, freed_count,
                   items_held, buckets_held, last, input ready);
   modport sink (input valid, status, chunk_id, present, hit_count, freed_count,
                 items_held, buckets_held, last, output ready);
endinterface

### rtl/bucketed_block_map_top.sv
// Sparse block map: logical block numbers map to 32-bit chunk ids, stored in a
// table of NUM_BUCKETS buckets of ENTRIES_PER_BUCKET entries that are taken on
// demand. One request is handled at a time and req_chan.ready is high only
// while the block is idle. The start block splits directly into bucket key
// and slot, since the bucket size is a power of two. Every block of the run
// then does a tag search that checks one bucket per cycle and stops early
// when the bucket is found; a mapped block then reads its entry from the entry
// RAM and writes it for add, or for remove when present, and for find every
// block gets one response handshake. Taking a new bucket during add clears its
// entries first. Flush sweeps the bucket table. Rejected requests and
// empty runs offer their result in the cycle after the request is accepted.
// No clearing pass is needed after reset.
module bucketed_block_map_top import bbm_pkg::*; #(
   parameter int NUM_BUCKETS = 16
) (
   input  logic      clock,
   input  logic      reset,
   bbm_req_if.sink   req_chan,
   bbm_rsp_if.source rsp_chan
);

`include "assert_macros.svh"

   localparam int OFF_W  = $clog2(ENTRIES_PER_BUCKET);
   localparam int KEY_W  = BLOCK_BITS - OFF_W;
   localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int BCNT_W = $clog2(NUM_BUCKETS + 1);
   localparam int DEPTH  = NUM_BUCKETS * ENTRIES_PER_BUCKET;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(ENTRIES_PER_BUCKET + 1);
   localparam int ITEM_W = $clog2(DEPTH + 1);

   // Control and run state.
   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [RUN_W-1:0]      len_ff, len_in;
   logic [RUN_W-1:0]      idx_ff, idx_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [BIDX_W-1:0]     scan_ff, scan_in;
   logic                  free_found_ff, free_found_in;
   logic [BIDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [BIDX_W-1:0]     cur_b_ff, cur_b_in;
   logic [OFF_W-1:0]      clr_ff, clr_in;
   logic [HIT_W-1:0]      hits_ff, hits_in;
   logic [BCNT_W-1:0]     freed_ff, freed_in;
   logic [ITEM_W-1:0]     items_ff, items_in;
   logic [BCNT_W-1:0]     buckets_ff, buckets_in;

   // Response register.
   status_type            rsp_status_ff, rsp_status_in;
   logic [CHUNK_W-1:0]    rsp_chunk_ff, rsp_chunk_in;
   logic                  rsp_present_ff, rsp_present_in;
   logic [HIT_W-1:0]      rsp_hits_ff, rsp_hits_in;
   logic [BCNT_W-1:0]     rsp_freed_ff, rsp_freed_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Bucket table.
   logic [NUM_BUCKETS-1:0] bkt_valid_ff;
   logic [KEY_W-1:0]       bkt_key_ff [NUM_BUCKETS];
   logic [FILL_W-1:0]      bkt_fill_ff [NUM_BUCKETS];

   // Bucket table update strobes.
   logic              alloc_en;
   logic [BIDX_W-1:0] alloc_idx;
   logic              fill_inc;
   logic              fill_dec;
   logic              release_en;
   logic [BIDX_W-1:0] release_idx;

   // Entry RAM signals.
   logic               ram_we;
   logic               ram_re;
   logic [CHUNK_W-1:0] ram_wdata;
   logic [CHUNK_W-1:0] ram_rdata;
   logic [ADDR_W-1:0]  ram_addr;
   logic [OFF_W-1:0]   slot_sel;

   // Helpers.
   logic               scan_match;
   logic               scan_free;
   logic               scan_last;
   logic               last_blk;
   logic               step_blk;
   logic               req_fire;
   logic               rsp_fire;
   op_type             req_op;
   logic [HIT_W-1:0]   hits_next;
   logic               rd_present;

   assign req_op   = op_type'(req_chan.operation);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // Entry address of the current bucket and slot (or clear pointer).
   assign slot_sel = (state_ff == S_CLEAR) ? clr_ff : off_ff;
   assign ram_addr = ADDR_W'(cur_b_ff) * ADDR_W'(ENTRIES_PER_BUCKET) + ADDR_W'(slot_sel);

   bbm_ram #(
      .WIDTH (CHUNK_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // Tag compare for the bucket under the scan pointer.
   assign scan_match = bkt_valid_ff[scan_ff] && (bkt_key_ff[scan_ff] == key_ff);
   assign scan_free  = !bkt_valid_ff[scan_ff];
   assign scan_last  = scan_ff == BIDX_W'(NUM_BUCKETS - 1);
   assign last_blk   = RUN_W'(idx_ff + RUN_W'(1)) == len_ff;

   assign rd_present = ram_rdata != '0;
   assign hits_next  = hits_ff + HIT_W'(rd_present);

   // Request ready and response channel outputs.
   assign req_chan.ready        = state_ff == S_IDLE;
   assign rsp_chan.valid        = state_ff == S_RESP;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.chunk_id     = rsp_chunk_ff;
   assign rsp_chan.present      = rsp_present_ff;
   assign rsp_chan.hit_count    = rsp_hits_ff;
   assign rsp_chan.freed_count  = FREED_W'(rsp_freed_ff);
   assign rsp_chan.items_held   = ITEMS_W'(items_ff);
   assign rsp_chan.buckets_held = BUCKETS_W'(buckets_ff);
   assign rsp_chan.last         = rsp_last_ff;

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         items_ff   <= '0;
         buckets_ff <= '0;
      end else begin
         state_ff   <= state_in;
         items_ff   <= items_in;
         buckets_ff <= buckets_in;
      end
   end

   // Working and response registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      len_ff         <= len_in;
      idx_ff         <= idx_in;
      chunk_ff       <= chunk_in;
      blk_ff         <= blk_in;
      key_ff         <= key_in;
      off_ff         <= off_in;
      scan_ff        <= scan_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      cur_b_ff       <= cur_b_in;
      clr_ff         <= clr_in;
      hits_ff        <= hits_in;
      freed_ff       <= freed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_chunk_ff   <= rsp_chunk_in;
      rsp_present_ff <= rsp_present_in;
      rsp_hits_ff    <= rsp_hits_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Bucket valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         bkt_valid_ff <= '0;
      end else begin
         if (alloc_en) begin
            bkt_valid_ff[alloc_idx] <= 1'b1;
         end
         if (release_en) begin
            bkt_valid_ff[release_idx] <= 1'b0;
         end
      end
   end

   // Bucket keys and fill counts; only read while the bucket is valid.
   always_ff @(posedge clock) begin
      if (alloc_en) begin
         bkt_key_ff[alloc_idx]  <= key_ff;
         bkt_fill_ff[alloc_idx] <= '0;
      end else if (fill_inc) begin
         bkt_fill_ff[cur_b_ff] <= bkt_fill_ff[cur_b_ff] + FILL_W'(1);
      end else if (fill_dec) begin
         bkt_fill_ff[cur_b_ff] <= bkt_fill_ff[cur_b_ff] - FILL_W'(1);
      end
   end

   // Sequencer: next state, strobes and response values.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      chunk_in       = chunk_ff;
      blk_in         = blk_ff;
      key_in         = key_ff;
      off_in         = off_ff;
      scan_in        = scan_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      cur_b_in       = cur_b_ff;
      clr_in         = clr_ff;
      hits_in        = hits_ff;
      freed_in       = freed_ff;
      items_in       = items_ff;
      buckets_in     = buckets_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_chunk_in   = rsp_chunk_ff;
      rsp_present_in = rsp_present_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_freed_in   = rsp_freed_ff;
      rsp_last_in    = rsp_last_ff;
      alloc_en       = 1'b0;
      alloc_idx      = scan_ff;
      fill_inc       = 1'b0;
      fill_dec       = 1'b0;
      release_en     = 1'b0;
      release_idx    = scan_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_wdata      = '0;
      step_blk       = 1'b0;

      case (state_ff)
         // Take a request and sort out the cases that need no walk.
         S_IDLE: begin
            if (req_fire) begin
               op_in          = req_op;
               len_in         = req_chan.run_length;
               chunk_in       = req_chan.new_chunk;
               blk_in         = req_chan.start_block;
               key_in         = req_chan.start_block[BLOCK_BITS-1:OFF_W];
               off_in         = req_chan.start_block[OFF_W-1:0];
               idx_in         = '0;
               hits_in        = '0;
               scan_in        = '0;
               freed_in       = '0;
               free_found_in  = 1'b0;
               rsp_status_in  = ST_OK;
               rsp_chunk_in   = '0;
               rsp_present_in = 1'b0;
               rsp_hits_in    = '0;
               rsp_freed_in   = '0;
               rsp_last_in    = 1'b1;
               if (req_op == OP_FLUSH) begin
                  state_in = S_FLUSH;
               end else if (req_chan.run_length > RUN_W'(MAX_RUN) ||
                            (req_op == OP_ADD && req_chan.new_chunk == '0)) begin
                  rsp_status_in = ST_BAD;
                  state_in      = S_RESP;
               end else if (req_chan.run_length == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         // Look for the bucket of the current block, one table slot a cycle.
         S_SEARCH: begin
            scan_in = scan_ff + BIDX_W'(1);
            if (scan_free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_ff;
            end
            if (scan_match) begin
               cur_b_in = scan_ff;
               state_in = S_READ;
            end else if (scan_last) begin
               case (op_ff)
                  OP_ADD: begin
                     if (free_found_ff || scan_free) begin
                        alloc_en   = 1'b1;
                        alloc_idx  = free_found_ff ? free_idx_ff : scan_ff;
                        cur_b_in   = alloc_idx;
                        buckets_in = buckets_ff + BCNT_W'(1);
                        clr_in     = '0;
                        state_in   = S_CLEAR;
                     end else begin
                        rsp_status_in = ST_NO_SPACE;
                        state_in      = S_RESP;
                     end
                  end
                  OP_FIND: begin
                     rsp_chunk_in   = '0;
                     rsp_present_in = 1'b0;
                     rsp_hits_in    = last_blk ? hits_ff : '0;
                     rsp_last_in    = last_blk;
                     state_in       = S_RESP;
                  end
                  default: begin
                     // Remove of an unmapped block: nothing to do.
                     if (last_blk) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SEARCH;
                        step_blk = 1'b1;
                     end
                  end
               endcase
            end
         end

         // Zero the entries of a freshly taken bucket.
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            clr_in    = clr_ff + OFF_W'(1);
            if (clr_ff == OFF_W'(ENTRIES_PER_BUCKET - 1)) begin
               state_in = S_READ;
            end
         end

         // Read the entry of the current block.
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_RDATA;
         end

         // Act on the entry read.
         S_RDATA: begin
            case (op_ff)
               OP_ADD: begin
                  ram_we    = 1'b1;
                  ram_wdata = chunk_ff;
                  if (!rd_present) begin
                     fill_inc = 1'b1;
                     items_in = items_ff + ITEM_W'(1);
                  end
                  if (last_blk) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                     step_blk = 1'b1;
                  end
               end
               OP_FIND: begin
                  hits_in        = hits_next;
                  rsp_chunk_in   = ram_rdata;
                  rsp_present_in = rd_present;
                  rsp_hits_in    = last_blk ? hits_next : '0;
                  rsp_last_in    = last_blk;
                  state_in       = S_RESP;
               end
               default: begin
                  if (rd_present) begin
                     ram_we    = 1'b1;
                     ram_wdata = '0;
                     fill_dec  = 1'b1;
                     items_in  = items_ff - ITEM_W'(1);
                     if (bkt_fill_ff[cur_b_ff] == FILL_W'(1)) begin
                        release_en  = 1'b1;
                        release_idx = cur_b_ff;
                        buckets_in  = buckets_ff - BCNT_W'(1);
                     end
                  end
                  if (last_blk) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                     step_blk = 1'b1;
                  end
               end
            endcase
         end

         // Release every bucket, one table slot a cycle.
         S_FLUSH: begin
            scan_in = scan_ff + BIDX_W'(1);
            if (bkt_valid_ff[scan_ff]) begin
               release_en  = 1'b1;
               release_idx = scan_ff;
               items_in    = items_ff - ITEM_W'(bkt_fill_ff[scan_ff]);
               buckets_in  = buckets_ff - BCNT_W'(1);
               freed_in    = freed_ff + BCNT_W'(1);
            end
            if (scan_last) begin
               rsp_freed_in = freed_in;
               state_in     = S_RESP;
            end
         end

         // Hold the result until it is taken.
         S_RESP: begin
            if (rsp_fire) begin
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SEARCH;
                  step_blk = 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Step to the next block of the run whenever the walk goes on.
      if (step_blk) begin
         idx_in        = idx_ff + RUN_W'(1);
         blk_in        = blk_ff + BLOCK_BITS'(1);
         scan_in       = '0;
         free_found_in = 1'b0;
         if (blk_ff == {BLOCK_BITS{1'b1}}) begin
            key_in = '0;
            off_in = '0;
         end else if (off_ff == OFF_W'(ENTRIES_PER_BUCKET - 1)) begin
            key_in = key_ff + KEY_W'(1);
            off_in = '0;
         end else begin
            off_in = off_ff + OFF_W'(1);
         end
      end
   end

   // The bucket count always agrees with the valid bits.
   `BBM_ASSERT_IMPL(a_bucket_count, clock, reset, 1'b1, $countones(bkt_valid_ff) == int'(buckets_ff))
   // A flush leaves no bucket in use by the time it answers.
   `BBM_ASSERT_IMPL(a_flush_empty, clock, reset, state_ff == S_RESP && op_ff == OP_FLUSH, bkt_valid_ff == '0)
   // The entry RAM is written only while a request is in progress.
   `BBM_ASSERT_IMPL(a_ram_busy, clock, reset, ram_we, state_ff != S_IDLE && state_ff != S_RESP)
   // An accepted request always moves the block out of idle in the next cycle.
   `BBM_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE)

endmodule

### rtl/bbm_ram.sv
// Simple dual-port RAM with a registered read.
module bbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### tb/sv/bbm_tb_scoreboard.sv
// Scoreboard for the block map: keeps a private copy of the map, works out the
// results of each accepted request and checks the responses against them.
package bbm_tb_scoreboard_pkg;
   import bbm_pkg::*;

   localparam int TB_EPB     = 64;
   localparam int TB_BUCKETS = 16;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [CHUNK_W-1:0]   chunk_id;
      logic                 present;
      logic [HIT_W-1:0]     hit_count;
      logic [FREED_W-1:0]   freed_count;
      logic [ITEMS_W-1:0]   items_held;
      logic [BUCKETS_W-1:0] buckets_held;
      logic                 last;
   } map_rsp_t;

   class map_scoreboard;
      bit                in_use [TB_BUCKETS];
      logic [41:0]       tag [TB_BUCKETS];
      int                fill [TB_BUCKETS];
      logic [31:0]       slots [TB_BUCKETS*TB_EPB];
      int                item_total;
      int                bucket_total;
      map_rsp_t          pending [$];
      int                mismatches;

      function new();
         for (int b = 0; b < TB_BUCKETS; b++) begin
            in_use[b] = 0;
            tag[b] = '0;
            fill[b] = 0;
         end
         foreach (slots[i]) slots[i] = '0;
         item_total = 0;
         bucket_total = 0;
         mismatches = 0;
      endfunction

      function int find_bucket(logic [41:0] key);
         for (int b = 0; b < TB_BUCKETS; b++)
            if (in_use[b] && tag[b] == key) return b;
         return -1;
      endfunction

      function int claim_bucket(logic [41:0] key);
         for (int b = 0; b < TB_BUCKETS; b++) begin
            if (!in_use[b]) begin
               for (int s = 0; s < TB_EPB; s++) slots[b*TB_EPB+s] = '0;
               in_use[b] = 1;
               tag[b] = key;
               fill[b] = 0;
               bucket_total++;
               return b;
            end
         end
         return -1;
      endfunction

      function void push(status_type st, logic [31:0] id, bit pres, int hits, int freed,
                         bit fin);
         map_rsp_t r;
         r.status = st;
         r.chunk_id = id;
         r.present = pres;
         r.hit_count = hits[HIT_W-1:0];
         r.freed_count = freed[FREED_W-1:0];
         r.items_held = item_total[ITEMS_W-1:0];
         r.buckets_held = bucket_total[BUCKETS_W-1:0];
         r.last = fin;
         pending.push_back(r);
      endfunction

      // Applies one accepted request to the map copy and queues its results.
      function void note_request(op_type op, logic [BLOCK_BITS-1:0] start,
                                 logic [RUN_W-1:0] len, logic [CHUNK_W-1:0] id);
         logic [BLOCK_BITS-1:0] blk;
         int b, off, hits, freed;
         status_type st;
         if (op == OP_FLUSH) begin
            freed = 0;
            for (int k = 0; k < TB_BUCKETS; k++) begin
               if (in_use[k]) begin
                  in_use[k] = 0;
                  item_total -= fill[k];
                  fill[k] = 0;
                  bucket_total--;
                  freed++;
               end
            end
            push(ST_OK, '0, 0, 0, freed, 1);
            return;
         end
         if (len > MAX_RUN || (op == OP_ADD && id == '0)) begin
            push(ST_BAD, '0, 0, 0, 0, 1);
            return;
         end
         if (op == OP_FIND && len == 0) begin
            push(ST_OK, '0, 0, 0, 0, 1);
            return;
         end
         st = ST_OK;
         hits = 0;
         for (int i = 0; i < len; i++) begin
            blk = start + i;
            off = blk[5:0];
            b = find_bucket(blk[47:6]);
            if (op == OP_ADD) begin
               if (b < 0) b = claim_bucket(blk[47:6]);
               if (b < 0) begin
                  st = ST_NO_SPACE;
                  break;
               end
               if (slots[b*TB_EPB+off] == '0) begin
                  fill[b]++;
                  item_total++;
               end
               slots[b*TB_EPB+off] = id;
            end else if (op == OP_REMOVE) begin
               if (b >= 0 && slots[b*TB_EPB+off] != '0) begin
                  slots[b*TB_EPB+off] = '0;
                  fill[b]--;
                  item_total--;
                  if (fill[b] == 0) begin
                     in_use[b] = 0;
                     bucket_total--;
                  end
               end
            end else begin
               logic [31:0] v;
               v = (b >= 0) ? slots[b*TB_EPB+off] : '0;
               if (v != '0) hits++;
               push(ST_OK, v, v != '0, (i == len-1) ? hits : 0, 0, i == len-1);
            end
         end
         if (op != OP_FIND) push(st, '0, 0, 0, 0, 1);
      endfunction

      // Compares one response with the oldest expected one.
      function void check_response(map_rsp_t got);
         map_rsp_t want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("response mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass
endpackage

### tb/sv/bucketed_block_map_top_tb.sv
module bucketed_block_map_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bbm_pkg::*;
   import bbm_tb_scoreboard_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 0;
   bit   stim_done = 0;
   logic [BLOCK_BITS-1:0] region;

   bbm_req_if req_chan ();
   bbm_rsp_if rsp_chan ();
   map_scoreboard map_sb = new();

   bucketed_block_map_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.operation = OP_ADD;
      req_chan.start_block = '0;
      req_chan.run_length = '0;
      req_chan.new_chunk = '0;
      rsp_chan.ready = 0;
   end

   // Sends one request item, with a random gap in front, and waits until taken.
   task automatic send_request(op_type op, logic [BLOCK_BITS-1:0] start, int len,
                               logic [31:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.operation <= op;
      req_chan.start_block <= start;
      req_chan.run_length <= len[RUN_W-1:0];
      req_chan.new_chunk <= id;
      do @(posedge clock); while (!req_chan.ready);
      map_sb.note_request(op, start, len[RUN_W-1:0], id);
   endtask

   // A random request aimed at a few small regions so that buckets collide.
   task automatic send_random();
      logic [BLOCK_BITS-1:0] start;
      int len, sel;
      op_type op;
      sel = $urandom_range(99);
      op = (sel < 45) ? OP_ADD : (sel < 65) ? OP_REMOVE : (sel < 97) ? OP_FIND : OP_FLUSH;
      start = region + $urandom_range(1400);
      if ($urandom_range(9) == 0) start = BLOCK_BITS'({$urandom, $urandom});
      len = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(12);
      send_request(op, start, len, ($urandom_range(29) == 0) ? 0 : $urandom);
   endtask

   // Response side: random stalls, checks every accepted item.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         map_sb.check_response('{rsp_chan.status, rsp_chan.chunk_id, rsp_chan.present,
                                 rsp_chan.hit_count, rsp_chan.freed_count,
                                 rsp_chan.items_held, rsp_chan.buckets_held,
                                 rsp_chan.last});
      rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long receiver hold-off while the sender keeps offering.
   initial begin
      wait (stim_done == 0 && !reset);
      repeat (400) @(posedge clock);
      hold_off = 1;
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      int idle_pct [4] = '{0, 57, 0, 28};
      int stall_pct [4] = '{0, 0, 57, 28};
      logic [BLOCK_BITS-1:0] top_blk;
      top_blk = '1;
      region = 48'h0000_0000_1000;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed cases: extremes, wraps and special cases.
      send_request(OP_FIND, 0, 0, 0);
      send_request(OP_ADD, 0, 0, 32'h1);
      send_request(OP_ADD, 10, 4, 0);
      send_request(OP_ADD, 10, 33, 5);
      send_request(OP_FIND, 10, 63, 0);
      send_request(OP_REMOVE, 10, 40, 0);
      send_request(OP_ADD, 60, 8, 32'hFFFF_FFFF);
      send_request(OP_ADD, 62, 2, 32'h1234_5678);
      send_request(OP_FIND, 58, 12, 0);
      send_request(OP_ADD, top_blk - 2, 5, 32'hA5A5_5A5A);
      send_request(OP_FIND, top_blk - 3, 32, 0);
      send_request(OP_REMOVE, top_blk, 3, 0);
      send_request(OP_FIND, top_blk - 3, 6, 0);
      send_request(OP_REMOVE, 0, 32, 0);
      send_request(OP_ADD, 48'h5555_5555_5555, 1, 32'h5555_5555);
      send_request(OP_ADD, 48'hAAAA_AAAA_AAAA, 1, 32'hAAAA_AAAA);
      for (int k = 0; k < 8; k++) send_request(OP_ADD, 1000 + 32 * k, 32, k + 1);
      send_request(OP_FIND, 1000, 32, 0);
      send_request(OP_FLUSH, 48'hFFFF_FFFF_FFFF, 63, 32'hFFFF_FFFF);
      send_request(OP_FLUSH, 0, 0, 0);

      // Random phases with different idle and stall rates.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         region = BLOCK_BITS'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
         for (int n = 0; n < 34; n++) send_random();
      end
      req_chan.valid <= 0;
      stim_done = 1;
      recv_stall_pct = 0;
      while (map_sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (map_sb.mismatches == 0 && map_sb.pending.size() == 0)
         $display("bucketed_block_map_top test passed");
      else
         $display("bucketed_block_map_top test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("bucketed_block_map_top test failed");
      $finish;
   end
endmodule
